FILE: rtl/spq_pkg.sv
// shared constants and types for the sorted priority queue
`default_nettype none

package spq_pkg;

    localparam int CAPACITY     = 16;
    localparam int PRIO_BITS    = 8;
    localparam int PAYLOAD_BITS = 16;
    localparam int FILL_BITS    = $clog2(CAPACITY + 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_spq_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_spq_status;

    typedef struct packed {
        t_spq_cmd                  command;
        logic [PRIO_BITS-1:0]      entry_priority;
        logic [PAYLOAD_BITS-1:0]   entry_payload;
    } t_spq_req;

    typedef struct packed {
        t_spq_status               status;
        logic [PRIO_BITS-1:0]      out_priority;
        logic [PAYLOAD_BITS-1:0]   out_payload;
        logic [FILL_BITS-1:0]      fill_level;
    } t_spq_rsp;

    typedef struct packed {
        logic [PRIO_BITS-1:0]      prio;
        logic [PAYLOAD_BITS-1:0]   payload;
    } t_spq_entry;

    typedef struct packed {
        logic shift_in;
        logic shift_out;
    } t_spq_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/spq_cell.sv
// one slot of the sorted queue, exchanging entries with its neighbors
`default_nettype none

module spq_cell (
    input  wire logic                   i_clk,
    input  wire spq_pkg::t_spq_cell_ctrl i_ctrl,
    input  wire logic                   i_occupied,
    input  wire spq_pkg::t_spq_entry    i_new,
    input  wire spq_pkg::t_spq_entry    i_left,
    input  wire logic                   i_left_keep,
    input  wire spq_pkg::t_spq_entry    i_right,
    output spq_pkg::t_spq_entry         o_entry,
    output logic                        o_keep
);

    spq_pkg::t_spq_entry r_entry;
    spq_pkg::t_spq_entry n_entry;
    logic                w_keep;

    // entries at or above the new priority stay put
    assign w_keep = i_occupied && (r_entry.prio >= i_new.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift_out) begin
            n_entry = i_right;
        end else if (i_ctrl.shift_in && !w_keep) begin
            if (i_left_keep) begin
                n_entry = i_new;
            end else begin
                n_entry = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_keep  = w_keep;

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue_core.sv
// sorted priority queue: a row of entry cells kept in descending priority order
//
// Requests arrive on i_req (valid/stall); each carries an insert or a remove.
// Every request yields exactly one response on o_rsp with a status, the
// removed entry (zero unless a remove succeeded) and the fill level after it.
// Equal priorities leave in arrival order. An insert into a full queue or a
// remove from an empty one leaves the contents alone and reports the reject.
// All cells compare against the new priority and shift in the same cycle, so
// one request is taken per clock while o_req_stall is low; its response
// appears in the output register on the next cycle.
// The output register lets a new request in while the previous response
// is taken in the same cycle; while the response is stalled, o_req_stall
// stays high and the response holds.
// A synchronous active-low reset empties the queue (fill level zero) and
// clears the response valid; cell contents are not cleared, and only slots
// below the fill level ever reach a response.
`default_nettype none

module sorted_priority_queue_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_stall,
    input  wire spq_pkg::t_spq_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_stall,
    output spq_pkg::t_spq_rsp   o_rsp
);

    localparam int CAP = spq_pkg::CAPACITY;
    localparam int FB  = spq_pkg::FILL_BITS;

    logic [FB-1:0]          r_count;
    logic [FB-1:0]          n_count;
    logic                   r_rsp_valid;
    spq_pkg::t_spq_rsp      r_rsp;
    spq_pkg::t_spq_rsp      n_rsp;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_do_ins;
    logic                   w_do_rem;
    spq_pkg::t_spq_entry    w_new;
    spq_pkg::t_spq_cell_ctrl w_ctrl;
    spq_pkg::t_spq_entry    w_entry [CAP];
    logic [CAP-1:0]         w_keep;
    logic [CAP-1:0]         w_occ;

    assign o_req_stall = r_rsp_valid && i_rsp_stall;
    assign w_accept    = i_req_valid && !o_req_stall;
    assign w_full      = (r_count == FB'(CAP));
    assign w_empty     = (r_count == '0);
    assign w_do_ins    = w_accept && (i_req.command == spq_pkg::CMD_INSERT) && !w_full;
    assign w_do_rem    = w_accept && (i_req.command == spq_pkg::CMD_REMOVE) && !w_empty;

    assign w_new.prio       = i_req.entry_priority;
    assign w_new.payload    = i_req.entry_payload;
    assign w_ctrl.shift_in  = w_do_ins;
    assign w_ctrl.shift_out = w_do_rem;

    for (genvar gi = 0; gi < CAP; gi++) begin : g_cell
        spq_pkg::t_spq_entry w_left;
        spq_pkg::t_spq_entry w_right;
        logic                w_left_keep;

        assign w_occ[gi] = (FB'(gi) < r_count);

        if (gi == 0) begin : g_first
            assign w_left      = w_new;
            assign w_left_keep = 1'b1;
        end else begin : g_mid
            assign w_left      = w_entry[gi-1];
            assign w_left_keep = w_keep[gi-1];
        end

        if (gi == CAP - 1) begin : g_last
            assign w_right = w_entry[gi];
        end else begin : g_inner
            assign w_right = w_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_occupied  (w_occ[gi]),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_entry     (w_entry[gi]),
            .o_keep      (w_keep[gi])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_do_ins) begin
            n_count = r_count + 1'b1;
        end else if (w_do_rem) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_rsp.status       = spq_pkg::ST_DONE;
        n_rsp.out_priority = '0;
        n_rsp.out_payload  = '0;
        n_rsp.fill_level   = n_count;
        if (i_req.command == spq_pkg::CMD_INSERT) begin
            if (w_full) begin
                n_rsp.status = spq_pkg::ST_FULL;
            end
        end else begin
            if (w_empty) begin
                n_rsp.status = spq_pkg::ST_EMPTY;
            end else begin
                n_rsp.out_priority = w_entry[0].prio;
                n_rsp.out_payload  = w_entry[0].payload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FB'(CAP))
        else $error("fill level above capacity");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_rem |=> r_count == $past(r_count) - 1'b1)
        else $error("remove did not drop the fill level");

    a_remove_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_rem |=> (o_rsp.out_priority == $past(w_entry[0].prio))
                  && (o_rsp.out_payload == $past(w_entry[0].payload)))
        else $error("removed entry is not the head");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= FB'(2)) |-> (w_entry[0].prio >= w_entry[1].prio))
        else $error("head out of priority order");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_do_ins && !w_do_rem) |=> $stable(r_count))
        else $error("rejected request changed the fill level");

endmodule

`default_nettype wire

FILE: tb/sorted_priority_queue_core_tb.sv
// self-checking regression bench for the sorted priority queue core
`timescale 1ns / 100ps

module sorted_priority_queue_core_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REQ_BITS    = $bits(spq_pkg::t_spq_req);

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_req_valid = 1'b0;
    logic                o_req_stall;
    spq_pkg::t_spq_req   i_req = '0;
    logic                o_rsp_valid;
    logic                i_rsp_stall = 1'b0;
    spq_pkg::t_spq_rsp   o_rsp;

    // bench copy of the queue contents, head at index 0
    spq_pkg::t_spq_entry    shadow_entries [spq_pkg::CAPACITY];
    int                     shadow_count = 0;
    spq_pkg::t_spq_rsp      pending_rsp_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cnt = 0;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;

    sorted_priority_queue_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("sorted_priority_queue_core regression: fail");
            $finish;
        end
    end

    // receiver side: long hold-off first, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            i_rsp_stall <= 1'b1;
            hold_cnt = hold_cnt - 1;
        end else begin
            i_rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic spq_pkg::t_spq_rsp predict_queue_op(input spq_pkg::t_spq_req req);
        spq_pkg::t_spq_rsp   rsp;
        int                  pos;
        rsp = '0;
        if (req.command == spq_pkg::CMD_INSERT) begin
            if (shadow_count >= spq_pkg::CAPACITY) begin
                rsp.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_entries[pos].prio >= req.entry_priority)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[pos].prio    = req.entry_priority;
                shadow_entries[pos].payload = req.entry_payload;
                shadow_count++;
                rsp.status = spq_pkg::ST_DONE;
            end
        end else begin
            if (shadow_count == 0) begin
                rsp.status = spq_pkg::ST_EMPTY;
            end else begin
                rsp.status       = spq_pkg::ST_DONE;
                rsp.out_priority = shadow_entries[0].prio;
                rsp.out_payload  = shadow_entries[0].payload;
                for (int i = 1; i < shadow_count; i++)
                    shadow_entries[i-1] = shadow_entries[i];
                shadow_count--;
            end
        end
        rsp.fill_level = spq_pkg::FILL_BITS'(shadow_count);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        spq_pkg::t_spq_rsp exp_rsp;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (pending_rsp_q.size() == 0) begin
                $error("unexpected response: status %0d prio %0d payload %0h fill %0d",
                       o_rsp.status, o_rsp.out_priority, o_rsp.out_payload,
                       o_rsp.fill_level);
                mismatch_cnt++;
            end else begin
                exp_rsp = pending_rsp_q.pop_front();
                if (o_rsp.status !== exp_rsp.status) begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, o_rsp.status);
                    mismatch_cnt++;
                end
                if (o_rsp.out_priority !== exp_rsp.out_priority) begin
                    $error("out_priority: expected %0d, got %0d",
                           exp_rsp.out_priority, o_rsp.out_priority);
                    mismatch_cnt++;
                end
                if (o_rsp.out_payload !== exp_rsp.out_payload) begin
                    $error("out_payload: expected %0h, got %0h",
                           exp_rsp.out_payload, o_rsp.out_payload);
                    mismatch_cnt++;
                end
                if (o_rsp.fill_level !== exp_rsp.fill_level) begin
                    $error("fill_level: expected %0d, got %0d",
                           exp_rsp.fill_level, o_rsp.fill_level);
                    mismatch_cnt++;
                end
            end
        end
    end

    // drives one request and waits until it is taken
    task automatic send_request(input spq_pkg::t_spq_cmd cmd,
                                input logic [spq_pkg::PRIO_BITS-1:0] prio,
                                input logic [spq_pkg::PAYLOAD_BITS-1:0] payload);
        spq_pkg::t_spq_req req;
        req.command        = cmd;
        req.entry_priority = prio;
        req.entry_payload  = payload;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_req_valid <= 1'b0;
            i_req       <= spq_pkg::t_spq_req'(REQ_BITS'($urandom));
        end
        @(negedge i_clk);
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (o_req_stall);
        pending_rsp_q.push_back(predict_queue_op(req));
    endtask

    task automatic insert_entry(input logic [spq_pkg::PRIO_BITS-1:0] prio,
                                input logic [spq_pkg::PAYLOAD_BITS-1:0] payload);
        send_request(spq_pkg::CMD_INSERT, prio, payload);
    endtask

    task automatic remove_head();
        send_request(spq_pkg::CMD_REMOVE, 8'($urandom), 16'($urandom));
    endtask

    task automatic test_remove_from_empty();
        remove_head();
        insert_entry(8'd42, 16'h1234);
        // sole entry leaves, then empty again
        remove_head();
        remove_head();
    endtask

    task automatic test_fill_and_reject();
        logic [spq_pkg::PRIO_BITS-1:0]    prios [spq_pkg::CAPACITY];
        logic [spq_pkg::PAYLOAD_BITS-1:0] loads [spq_pkg::CAPACITY];
        prios = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd7, 8'd255, 8'd0,
                  8'd1, 8'd254, 8'd128, 8'd64, 8'd64, 8'd3, 8'd200, 8'd128};
        loads = '{16'hffff, 16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'haaaa,
                  16'h5555, 16'hfffe, 16'h8000, 16'h7fff, 16'h0004, 16'h00ff,
                  16'hff00, 16'h0f0f, 16'hf0f0, 16'h0005};
        for (int i = 0; i < spq_pkg::CAPACITY; i++)
            insert_entry(prios[i], loads[i]);
        insert_entry(8'd255, 16'hdead);
    endtask

    task automatic test_partial_drain();
        repeat (5) remove_head();
    endtask

    task automatic test_random_traffic(input int n_items);
        int insert_pct;
        int burst_len;
        int sent;
        logic [spq_pkg::PRIO_BITS-1:0] prio;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(2))
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            burst_len = $urandom_range(40, 10);
            for (int k = 0; k < burst_len && sent < n_items; k++) begin
                if ($urandom_range(99) < insert_pct) begin
                    // narrow range most of the time so ties are common
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: prio = 8'($urandom_range(7));
                        5, 6:          prio = 8'($urandom);
                        7:             prio = 8'($urandom_range(255, 248));
                        default:       prio = ($urandom_range(1)) ? 8'd255 : 8'd0;
                    endcase
                    insert_entry(prio, 16'($urandom));
                end else begin
                    remove_head();
                end
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        hold_cnt = 48;
        send_idle_pct = 0;
        for (int k = 0; k < 30; k++) begin
            if (k % 3 == 2)
                remove_head();
            else
                insert_entry(8'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        send_idle_pct = 37;
        recv_idle_pct = 58;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_remove_from_empty();
        test_fill_and_reject();
        test_partial_drain();
        test_random_traffic(270);

        send_idle_pct = 58;
        recv_idle_pct = 37;
        test_random_traffic(270);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(230);
        test_backpressure();
        test_random_traffic(30);

        @(negedge i_clk);
        i_req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("sorted_priority_queue_core regression: pass");
        else
            $display("sorted_priority_queue_core regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
tb/sorted_priority_queue_core_tb.sv
